FILE: rtl/core/bam_pkg.sv
package bam_pkg;

   localparam int MAP_BITS  = 1024;
   localparam int WORD_BITS = 16;
   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_AW    = $clog2(WORD_BITS);
   localparam int POS_W     = WORD_AW + BIT_AW;

   localparam int OPCODE_W = 2;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 11;
   localparam int FOUND_W  = 11;

   localparam logic [OPCODE_W-1:0] OP_TEST  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_SET   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_FIND  = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [INDEX_W-1:0]  bit_index;
      logic [LENGTH_W-1:0] search_length;
   } req_type;

   typedef struct packed {
      logic               old_bit;
      logic [FOUND_W-1:0] found_index;
   } rsp_type;

   typedef struct packed {
      logic              old_bit;
      word_type          new_word;
      logic              free_any;
      logic [BIT_AW-1:0] zero_pos;
   } unit_out_type;

endpackage

FILE: rtl/core/bitmap_allocation_map_top.sv
// Allocation bitmap of MAP_BITS bits held in a single-port-read word RAM and
// cleared at reset by per-word valid flags, so no clearing pass is needed. A
// request is taken when start is high and busy is low, and its single result
// appears for exactly one cycle with rsp_valid high; it must be captured then.
// Test, set and clear pass through the read state, then the modify-and-write
// state, which registers their result. A find reads one word per cycle
// through the RAM read port and returns its beat once a free bit is found, the
// length is reached or the last word has been checked.
// Busy falls in the cycle the result is shown, so a new request may be
// accepted in that same cycle.
module bitmap_allocation_map_top
   import bam_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_BIT  = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [FOUND_W-1:0]   lim_ff, lim_in;
   logic [WORD_AW:0]     rd_ptr_ff, rd_ptr_in;
   logic [WORD_AW:0]     chk_ptr_ff, chk_ptr_in;
   logic                 pend_ff, pend_in;
   logic                 rvld_ff;
   logic [MAP_WORDS-1:0] valid_ff, valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_AW-1:0]   req_word;
   word_type             rd_data;
   word_type             eff_word;
   logic                 ram_we;
   logic                 in_map;
   unit_out_type         unit_out;
   logic [POS_W-1:0]     base;
   logic [FOUND_W-1:0]   base_ext;
   logic [FOUND_W-1:0]   pos_ext;

   assign req_word = req_ff.bit_index[BIT_AW +: WORD_AW];
   assign in_map   = (32'(req_ff.bit_index) < MAP_BITS);
   assign eff_word = rvld_ff ? rd_data : '0;
   assign base     = {chk_ptr_ff[WORD_AW-1:0], {BIT_AW{1'b0}}};
   assign base_ext = FOUND_W'(base);
   assign pos_ext  = base_ext + FOUND_W'(unit_out.zero_pos);

   always_comb begin
      case (state_ff)
         S_READ:  rd_addr = req_word;
         S_SCAN:  rd_addr = rd_ptr_ff[WORD_AW-1:0];
         default: rd_addr = '0;
      endcase
   end

   assign ram_we = (state_ff == S_BIT) && in_map &&
                   ((req_ff.opcode == OP_SET) || (req_ff.opcode == OP_CLEAR));

   bam_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAP_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_word),
      .wr_data (unit_out.new_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bam_word_unit u_unit (
      .word    (eff_word),
      .bit_sel (req_ff.bit_index[BIT_AW-1:0]),
      .set_val (req_ff.opcode == OP_SET),
      .result  (unit_out)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      lim_in       = lim_ff;
      rd_ptr_in    = rd_ptr_ff;
      chk_ptr_in   = chk_ptr_ff;
      pend_in      = pend_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in    = req_data;
               lim_in    = (32'(req_data.search_length) > MAP_BITS) ?
                           FOUND_W'(MAP_BITS) : FOUND_W'(req_data.search_length);
               rd_ptr_in = '0;
               pend_in   = 1'b0;
               state_in  = (req_data.opcode == OP_FIND) ? S_SCAN : S_READ;
            end
         end
         S_READ: begin
            state_in = S_BIT;
         end
         S_BIT: begin
            rsp_valid_in        = 1'b1;
            rsp_in.old_bit      = in_map ? unit_out.old_bit : 1'b0;
            rsp_in.found_index  = '0;
            if (ram_we) begin
               valid_in[req_word] = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_SCAN: begin
            rd_ptr_in  = rd_ptr_ff + 1'b1;
            chk_ptr_in = rd_ptr_ff;
            pend_in    = 1'b1;
            if (pend_ff) begin
               rsp_in.old_bit = 1'b0;
               if (base_ext >= lim_ff) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.found_index = lim_ff;
                  state_in           = S_IDLE;
               end else if (unit_out.free_any) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.found_index = (pos_ext < lim_ff) ? pos_ext : lim_ff;
                  state_in           = S_IDLE;
               end else if (32'(chk_ptr_ff) == MAP_WORDS - 1) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.found_index = lim_ff;
                  state_in           = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rvld_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         rvld_ff      <= valid_ff[rd_addr];
      end
      req_ff     <= req_in;
      lim_ff     <= lim_in;
      rd_ptr_ff  <= rd_ptr_in;
      chk_ptr_ff <= chk_ptr_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("Result shown without a request in progress.");

   a_rsp_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.old_bit && (rsp_data.found_index != '0)))
      else $error("Result carries both a bit value and an index.");

   a_write_then_rsp: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (rsp_valid && !busy))
      else $error("Map write not followed by its result.");

   a_find_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(state_ff == S_SCAN)) |-> (rsp_data.found_index <= $past(lim_ff)))
      else $error("Find result exceeds the search length.");
`endif

endmodule

FILE: rtl/core/bam_ram.sv
module bam_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: rtl/core/bam_word_unit.sv
module bam_word_unit
   import bam_pkg::*;
(
   input  word_type          word,
   input  logic [BIT_AW-1:0] bit_sel,
   input  logic              set_val,
   output unit_out_type      result
);

   word_type free_bits;
   logic [BIT_AW-1:0] pos;

   assign free_bits = ~word;

   always_comb begin
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pos = BIT_AW'(i);
         end
      end
   end

   always_comb begin
      result.old_bit  = word[bit_sel];
      result.new_word = word;
      result.new_word[bit_sel] = set_val;
      result.free_any = |free_bits;
      result.zero_pos = pos;
   end

endmodule
